// File: design/packed_pixel_framebuffer_access_assert.svh
// Assertion macros used by the controller.
`ifndef PACKED_PIXEL_FRAMEBUFFER_ACCESS_ASSERT_SVH
`define PACKED_PIXEL_FRAMEBUFFER_ACCESS_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PPFB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PPFB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ppfb_pkg.sv
package ppfb_pkg;

  localparam int MEM_BYTES_DEF   = 131072;
  localparam int PAL_ENTRIES_DEF = 256;

  localparam int AREA_W = 22;
  localparam int LIM_W  = 23;
  localparam int OFF_W  = 24;
  localparam int CMP_W  = 25;
  localparam int PADDR_W = 4;

  localparam logic [1:0] REG_DEPTH  = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [10:0] WIDTH_RST  = 11'd320;
  localparam logic [10:0] HEIGHT_RST = 11'd240;

  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;

  typedef enum logic [2:0] {
    ACT_PIX_WR   = 3'd0,
    ACT_PIX_RD   = 3'd1,
    ACT_COLOR_RD = 3'd2,
    ACT_PAL_WR   = 3'd3,
    ACT_PAL_RD   = 3'd4
  } action_t;

  typedef struct packed {
    logic [2:0]        depth;
    logic [10:0]       width;
    logic [10:0]       height;
    logic [AREA_W-1:0] area;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic mul_en;
    logic loc_en;
    logic fr_rd;
    logic fr_wr;
    logic fr_merge;
    logic pix_en;
    logic pal_rd;
    logic pal_wr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    action_t act;
    logic    loc_ok;
    logic    sub_byte;
    logic    depth16;
  } sts_t;

  // log2 of pixels per byte, used for the coordinate shifts
  function automatic logic [1:0] coord_shift(input logic [2:0] depth);
    logic [1:0] s;
    case (depth)
      DEPTH_1BPP: s = 2'd3;
      DEPTH_2BPP: s = 2'd2;
      DEPTH_4BPP: s = 2'd1;
      default:    s = 2'd0;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] pix_mask(input logic [2:0] depth);
    logic [7:0] m;
    case (depth)
      DEPTH_1BPP: m = 8'h01;
      DEPTH_2BPP: m = 8'h03;
      DEPTH_4BPP: m = 8'h0f;
      default:    m = 8'hff;
    endcase
    return m;
  endfunction

  // MSB-first packing: pixel 0 sits in the top bits
  function automatic logic [2:0] bit_pos(input logic [2:0] depth, input logic [2:0] xl);
    logic [2:0] p;
    case (depth)
      DEPTH_1BPP: p = 3'd7 - xl;
      DEPTH_2BPP: p = {2'd3 - xl[1:0], 1'b0};
      DEPTH_4BPP: p = xl[0] ? 3'd0 : 3'd4;
      default:    p = 3'd0;
    endcase
    return p;
  endfunction

endpackage

// File: design/packed_pixel_framebuffer_access.sv
// Packed-pixel framebuffer with a 16-bit palette. Each input beat performs one
// action: write a pixel, read a pixel index, read a pixel color through the
// palette, write a palette entry or read one; each gives exactly one result
// beat (read_data, ok). Pixels are packed MSB-first at 1, 2, 4 or 8 bpp, and
// 16bpp pixels are stored big-endian in two bytes. The frame store is two
// byte-wide single-port banks (even and odd byte addresses) with registered
// reads. An item holds the engine through the finish state: unused codes go
// there directly, palette actions via a palette access, 8/16bpp pixel writes
// and out-of-window accesses via the multiply, locate and access states;
// sub-byte writes (byte read and rewrite), index reads and 16bpp color reads
// add a merge or pixel step, color reads at 1 to 8bpp a pixel step and a
// palette read. The finish state waits for the result register to drain. A
// new beat is taken while the previous result is still held. Configuration
// registers (depth_mode at 0x0, the row width in pixels at 0x4, the row count
// at 0x8) must be written by the user through the APB port while the block is
// idle (not enforced); the bound check uses a registered width times height.
module packed_pixel_framebuffer_access import ppfb_pkg::*; #(
  parameter int MEM_BYTES       = MEM_BYTES_DEF,
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic [9:0]         in_pos_x,
  input  logic [9:0]         in_pos_y,
  input  logic [15:0]        in_value,
  input  logic [7:0]         in_palette_slot,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_read_data,
  output logic               out_ok,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  ppfb_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppfb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ppfb_dpath #(
    .MEM_BYTES       (MEM_BYTES),
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dpath (
    .clk             (clk),
    .cfg             (cfg),
    .cmd             (cmd),
    .sts             (sts),
    .in_action       (in_action),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_value        (in_value),
    .in_palette_slot (in_palette_slot),
    .out_read_data   (out_read_data),
    .out_ok          (out_ok)
  );

endmodule

// File: design/ppfb_regs.sv
module ppfb_regs import ppfb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg
);

  logic [2:0]        depth_r;
  logic [10:0]       width_r;
  logic [10:0]       height_r;
  logic [AREA_W-1:0] area_r;
  logic              wr_en;
  logic [1:0]        reg_idx;

  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r  <= DEPTH_1BPP;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
      area_r   <= AREA_W'(WIDTH_RST) * AREA_W'(HEIGHT_RST);
    end else begin
      if (wr_en) begin
        unique case (reg_idx)
          REG_DEPTH:  depth_r  <= pwdata[2:0];
          REG_WIDTH:  width_r  <= pwdata[10:0];
          REG_HEIGHT: height_r <= pwdata[10:0];
          default: ;
        endcase
      end
      // window area, kept current for the bound check
      area_r <= AREA_W'(width_r) * AREA_W'(height_r);
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEPTH:  prdata = {29'd0, depth_r};
      REG_WIDTH:  prdata = {21'd0, width_r};
      REG_HEIGHT: prdata = {21'd0, height_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign cfg = '{depth: depth_r, width: width_r, height: height_r, area: area_r};

endmodule

// File: design/ppfb_ctrl.sv
module ppfb_ctrl import ppfb_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_action,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  `include "packed_pixel_framebuffer_access_assert.svh"

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_LOC, ST_ACC, ST_MERGE, ST_PIXD, ST_PALA, ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  logic   out_free;
  logic   is_write;

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = ~out_valid_r | ~out_stall;
  assign is_write  = (sts.act == ACT_PIX_WR);

  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (action_t'(in_action)) inside
            ACT_PIX_WR, ACT_PIX_RD, ACT_COLOR_RD: state_nxt = ST_MUL;
            ACT_PAL_WR, ACT_PAL_RD:               state_nxt = ST_PALA;
            default:                              state_nxt = ST_FIN;
          endcase
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_nxt  = ST_LOC;
      end
      ST_LOC: begin
        cmd.loc_en = 1'b1;
        state_nxt  = ST_ACC;
      end
      ST_ACC: begin
        if (!sts.loc_ok) begin
          state_nxt = ST_FIN;
        end else if (is_write && !sts.sub_byte) begin
          cmd.fr_wr = 1'b1;
          state_nxt = ST_FIN;
        end else if (is_write) begin
          cmd.fr_rd = 1'b1;
          state_nxt = ST_MERGE;
        end else begin
          cmd.fr_rd = 1'b1;
          state_nxt = ST_PIXD;
        end
      end
      ST_MERGE: begin
        cmd.fr_merge = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_PIXD: begin
        cmd.pix_en = 1'b1;
        if (sts.act == ACT_COLOR_RD && !sts.depth16) state_nxt = ST_PALA;
        else state_nxt = ST_FIN;
      end
      ST_PALA: begin
        cmd.pal_wr = (sts.act == ACT_PAL_WR);
        cmd.pal_rd = (sts.act != ACT_PAL_WR);
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        cmd.out_load = out_free;
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PPFB_ASSERT_NOW(a_frame_needs_ok, (cmd.fr_rd || cmd.fr_wr || cmd.fr_merge), sts.loc_ok,
    "frame access issued for an offset outside the window")
  `PPFB_ASSERT_NOW(a_merge_after_read, cmd.fr_merge, $past(cmd.fr_rd),
    "byte merge without a preceding frame read")
  `PPFB_ASSERT_NOW(a_no_overwrite, cmd.out_load, (!out_valid_r || !out_stall),
    "result loaded over a stalled beat")
  `PPFB_ASSERT_NEXT(a_busy_after_accept, accept, in_stall,
    "input not stalled right after accept")

endmodule

// File: design/ppfb_dpath.sv
module ppfb_dpath import ppfb_pkg::*; #(
  parameter int MEM_BYTES       = MEM_BYTES_DEF,
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  logic        clk,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [2:0]  in_action,
  input  logic [9:0]  in_pos_x,
  input  logic [9:0]  in_pos_y,
  input  logic [15:0] in_value,
  input  logic [7:0]  in_palette_slot,
  output logic [15:0] out_read_data,
  output logic        out_ok
);

  localparam int BANK_DEPTH = (MEM_BYTES + 1) / 2;
  localparam int BA_W       = $clog2(BANK_DEPTH);
  localparam int PAL_W      = $clog2(PALETTE_ENTRIES);

  // even bank holds the high byte of a 16bpp pixel
  logic [7:0]  even_mem [BANK_DEPTH];
  logic [7:0]  odd_mem  [BANK_DEPTH];
  logic [15:0] pal_mem  [PALETTE_ENTRIES];

  action_t          act_r;
  logic [9:0]       x_r;
  logic [9:0]       y_r;
  logic [15:0]      val_r;
  logic [7:0]       slot_r;
  logic [20:0]      prod_r;
  logic [OFF_W-1:0] off_r;
  logic             ok_r;
  logic [7:0]       even_q;
  logic [7:0]       odd_q;
  logic [15:0]      pix_r;
  logic [15:0]      pal_q;
  logic [15:0]      rd_data_r;
  logic             ok_out_r;

  logic [1:0]       shamt;
  logic [10:0]      w_sh;
  logic             depth16;
  logic             sub_byte;
  logic [21:0]      sum;
  logic [OFF_W-1:0] off_nxt;
  logic [LIM_W-1:0] lim;
  logic             ok_nxt;
  logic [BA_W-1:0]  bank_addr;
  logic [7:0]       byte_q;
  logic [2:0]       bp;
  logic [7:0]       mask;
  logic [7:0]       bmask;
  logic [7:0]       merged;
  logic [7:0]       sub_pix;
  logic             even_we;
  logic             odd_we;
  logic [7:0]       even_wd;
  logic [7:0]       odd_wd;
  logic [7:0]       pal_idx;
  logic             pal_hit;
  logic             slot_hit;
  logic [15:0]      res_data;
  logic             res_ok;

  assign shamt    = coord_shift(cfg.depth);
  assign w_sh     = cfg.width >> shamt;
  assign depth16  = (cfg.depth == DEPTH_16BPP);
  assign sub_byte = (cfg.depth < DEPTH_8BPP);
  assign mask     = pix_mask(cfg.depth);
  assign bp       = bit_pos(cfg.depth, x_r[2:0]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r  <= action_t'(in_action);
      x_r    <= in_pos_x;
      y_r    <= in_pos_y;
      val_r  <= in_value;
      slot_r <= in_palette_slot;
    end
    if (cmd.mul_en) prod_r <= 21'(w_sh) * 21'(y_r);
    if (cmd.loc_en) begin
      off_r <= off_nxt;
      ok_r  <= ok_nxt;
    end
  end

  // byte offset and window bound
  assign sum     = 22'(prod_r) + 22'(x_r >> shamt);
  assign off_nxt = depth16 ? {1'b0, sum, 1'b0} : {2'b00, sum};

  always_comb begin
    case (cfg.depth)
      DEPTH_1BPP:  lim = LIM_W'(cfg.area >> 3);
      DEPTH_2BPP:  lim = LIM_W'(cfg.area >> 2);
      DEPTH_4BPP:  lim = LIM_W'(cfg.area >> 1);
      DEPTH_8BPP:  lim = LIM_W'(cfg.area);
      DEPTH_16BPP: lim = {cfg.area, 1'b0};
      default:     lim = '0;
    endcase
  end

  assign ok_nxt = (cfg.depth <= DEPTH_16BPP)
                  && (CMP_W'(off_nxt) < CMP_W'(lim))
                  && ((CMP_W'(off_nxt) + (depth16 ? CMP_W'(2) : CMP_W'(1)))
                      <= CMP_W'(MEM_BYTES));

  // frame store
  assign bank_addr = off_r[BA_W:1];
  assign byte_q    = off_r[0] ? odd_q : even_q;
  assign bmask     = mask << bp;
  assign merged    = (byte_q & ~bmask) | ((val_r[7:0] << bp) & bmask);
  assign sub_pix   = (byte_q >> bp) & mask;

  assign even_we = (cmd.fr_wr && (depth16 || !off_r[0])) || (cmd.fr_merge && !off_r[0]);
  assign odd_we  = (cmd.fr_wr && (depth16 || off_r[0]))  || (cmd.fr_merge && off_r[0]);
  assign even_wd = depth16 ? val_r[15:8] : (cmd.fr_merge ? merged : val_r[7:0]);
  assign odd_wd  = cmd.fr_merge ? merged : val_r[7:0];

  always_ff @(posedge clk) begin
    if (even_we) even_mem[bank_addr] <= even_wd;
    if (cmd.fr_rd) even_q <= even_mem[bank_addr];
  end

  always_ff @(posedge clk) begin
    if (odd_we) odd_mem[bank_addr] <= odd_wd;
    if (cmd.fr_rd) odd_q <= odd_mem[bank_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.pix_en) pix_r <= depth16 ? {even_q, odd_q} : {8'h00, sub_pix};
  end

  // palette
  assign pal_idx  = (act_r == ACT_COLOR_RD) ? pix_r[7:0] : (slot_r & mask);
  assign pal_hit  = ({1'b0, pal_idx} < 9'(PALETTE_ENTRIES));
  assign slot_hit = ({1'b0, slot_r} < 9'(PALETTE_ENTRIES));

  always_ff @(posedge clk) begin
    if (cmd.pal_wr && slot_hit) pal_mem[slot_r[PAL_W-1:0]] <= val_r;
    if (cmd.pal_rd) pal_q <= pal_mem[pal_idx[PAL_W-1:0]];
  end

  always_comb begin
    res_data = 16'h0000;
    res_ok   = 1'b0;
    case (act_r)
      ACT_PIX_WR: res_ok = ok_r;
      ACT_PIX_RD: begin
        res_ok   = ok_r;
        res_data = ok_r ? pix_r : 16'h0000;
      end
      ACT_COLOR_RD: begin
        res_ok = ok_r;
        if (ok_r && depth16) res_data = pix_r;
        else if (ok_r && pal_hit) res_data = pal_q;
      end
      ACT_PAL_WR: res_ok = slot_hit;
      ACT_PAL_RD: begin
        if (cfg.depth > DEPTH_8BPP) begin
          res_ok = 1'b1;
        end else if (pal_hit) begin
          res_ok   = 1'b1;
          res_data = pal_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rd_data_r <= res_data;
      ok_out_r  <= res_ok;
    end
  end

  assign out_read_data = rd_data_r;
  assign out_ok        = ok_out_r;

  assign sts = '{act: act_r, loc_ok: ok_r, sub_byte: sub_byte, depth16: depth16};

endmodule
